// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- rtl/mmm_pkg.sv -----
// Shared types and constants for the Montgomery multiplier.
// No dependencies.
`default_nettype none

package mmm_pkg;

    localparam int LimbCount  = 4;
    localparam int LimbWidth  = 64;
    localparam int HalfWidth  = LimbWidth / 2;
    localparam int AccWidth   = LimbWidth * (LimbCount + 2);
    // pipeline stages inside one cell
    localparam int CellStages = 5;

    typedef logic [LimbWidth-1:0] limb_t;
    typedef limb_t [LimbCount-1:0] num_t;
    // accumulator: LimbCount+2 limbs, the limbs above the low LimbCount hold the carries
    typedef limb_t [LimbCount+1:0] acc_t;
    // four 32x32 partial products of one limb pair: lo*lo, lo*hi, hi*lo, hi*hi
    typedef limb_t [3:0] quad_t;

    // register indexes
    localparam int RegNegInv = LimbCount;

endpackage

`default_nettype wire

// ----- rtl/mmm_cell.sv -----
// One step of the interleaved (CIOS) Montgomery loop: t = (t + a_i*b + m*p) / 2^64.
// Uses mmm_pkg. Five pipeline stages built on 32x32 multipliers.
`default_nettype none

module mmm_cell
    import mmm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  limb_t      a_limb,
    input  num_t       b,
    input  num_t       a_rest,
    input  acc_t       t_in,
    input  num_t       modulus,
    input  limb_t      neg_inverse,
    output logic       out_valid,
    output num_t       b_out,
    output num_t       a_rest_out,
    output acc_t       t_out
);

    logic [CellStages-1:0] valid_reg;
    num_t  b_pipe_reg [CellStages];
    num_t  a_pipe_reg [CellStages];
    quad_t ab_pp_next [LimbCount];
    quad_t ab_pp_reg  [LimbCount];
    acc_t  t1_reg;
    acc_t  s_next;
    acc_t  s2_reg;
    limb_t mpp0, mpp1, mpp2;
    limb_t m_next;
    limb_t m3_reg;
    acc_t  s3_reg;
    quad_t mp_pp_next [LimbCount];
    quad_t mp_pp_reg  [LimbCount];
    acc_t  s4_reg;
    acc_t  u_sum;
    acc_t  t_next;
    acc_t  t_reg;

    function automatic limb_t mul_half(input logic [HalfWidth-1:0] x,
                                       input logic [HalfWidth-1:0] y);
        return {{HalfWidth{1'b0}}, x} * {{HalfWidth{1'b0}}, y};
    endfunction

    function automatic quad_t split_mul(input limb_t x, input limb_t y);
        quad_t q;
        q[0] = mul_half(x[HalfWidth-1:0], y[HalfWidth-1:0]);
        q[1] = mul_half(x[HalfWidth-1:0], y[LimbWidth-1:HalfWidth]);
        q[2] = mul_half(x[LimbWidth-1:HalfWidth], y[HalfWidth-1:0]);
        q[3] = mul_half(x[LimbWidth-1:HalfWidth], y[LimbWidth-1:HalfWidth]);
        return q;
    endfunction

    // full 128-bit product from its four partials
    function automatic logic [2*LimbWidth-1:0] join_mul(input quad_t q);
        logic [LimbWidth:0] mid;
        mid = {1'b0, q[1]} + {1'b0, q[2]};
        return {q[3], q[0]} + ((2*LimbWidth)'(mid) << HalfWidth);
    endfunction

    // stage 1: partial products of a_i * b
    always_comb
    begin
        for (int j = 0; j < LimbCount; j++)
            ab_pp_next[j] = split_mul(a_limb, b[j]);
    end

    // stage 2: s = t + a_i * b
    always_comb
    begin
        s_next = t1_reg;
        for (int j = 0; j < LimbCount; j++)
            s_next = s_next + (AccWidth'(join_mul(ab_pp_reg[j])) << (LimbWidth * j));
    end

    // stage 3: m = s[0] * neg_inverse mod 2^64
    always_comb
    begin
        mpp0   = mul_half(s2_reg[0][HalfWidth-1:0], neg_inverse[HalfWidth-1:0]);
        mpp1   = mul_half(s2_reg[0][HalfWidth-1:0], neg_inverse[LimbWidth-1:HalfWidth]);
        mpp2   = mul_half(s2_reg[0][LimbWidth-1:HalfWidth], neg_inverse[HalfWidth-1:0]);
        m_next = mpp0 + {mpp1[HalfWidth-1:0] + mpp2[HalfWidth-1:0], {HalfWidth{1'b0}}};
    end

    // stage 4: partial products of m * p
    always_comb
    begin
        for (int j = 0; j < LimbCount; j++)
            mp_pp_next[j] = split_mul(m3_reg, modulus[j]);
    end

    // stage 5: u = s + m*p, then shift one limb
    always_comb
    begin
        u_sum = s4_reg;
        for (int j = 0; j < LimbCount; j++)
            u_sum = u_sum + (AccWidth'(join_mul(mp_pp_reg[j])) << (LimbWidth * j));
        t_next = u_sum >> LimbWidth;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[CellStages-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        b_pipe_reg[0] <= b;
        a_pipe_reg[0] <= a_rest;
        for (int k = 1; k < CellStages; k++)
        begin
            b_pipe_reg[k] <= b_pipe_reg[k-1];
            a_pipe_reg[k] <= a_pipe_reg[k-1];
        end
        ab_pp_reg <= ab_pp_next;
        t1_reg    <= t_in;
        s2_reg    <= s_next;
        m3_reg    <= m_next;
        s3_reg    <= s2_reg;
        mp_pp_reg <= mp_pp_next;
        s4_reg    <= s3_reg;
        t_reg     <= t_next;
    end

    assign out_valid  = valid_reg[CellStages-1];
    assign b_out      = b_pipe_reg[CellStages-1];
    assign a_rest_out = a_pipe_reg[CellStages-1];
    assign t_out      = t_reg;

endmodule

`default_nettype wire

// ----- rtl/mmm_final.sv -----
// Final conditional subtraction of p and result register.
// Uses mmm_pkg.
`default_nettype none

module mmm_final
    import mmm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  acc_t      t_in,
    input  num_t      modulus,
    output logic      out_valid,
    output num_t      res
);

    logic [LimbCount*LimbWidth:0] diff;
    logic [LimbCount*LimbWidth-1:0] lowv, pv;
    logic valid_reg;
    num_t res_reg, res_next;

    // subtract p when limb LimbCount of t is nonzero or the subtraction has no borrow
    always_comb
    begin
        lowv = t_in[LimbCount-1:0];
        pv   = modulus;
        diff = {1'b0, lowv} - {1'b0, pv};
        if ((t_in[LimbCount] != '0) || !diff[LimbCount*LimbWidth])
            res_next = diff[LimbCount*LimbWidth-1:0];
        else
            res_next = lowv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ----- rtl/montgomery_modular_multiplier.sv -----
// Top level: configuration registers, chain of CIOS cells, final subtraction.
// Uses mmm_pkg, mmm_cell, mmm_final, assert_macros.svh.
//
// channel  | ports                              | handshake
// config   | cfg_we, cfg_index, cfg_data        | write when cfg_we
// operands | a_limb0..3, b_limb0..3             | start && !busy
// result   | product_limb0..3                   | done strobe, one cycle
//
// Each cell is a 5-stage pipeline (a_i*b partials, add, m, m*p partials, add and shift).
// LimbCount cells plus one subtraction stage lie between accept and done.
// An item may enter every cycle; busy stays low.
// Reset clears valid bits and configuration; results cannot be stalled.
`default_nettype none

module montgomery_modular_multiplier
    import mmm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_we,
    input  wire logic [2:0] cfg_index,
    input  limb_t       cfg_data,
    input  wire logic   start,
    output logic        busy,
    input  limb_t       a_limb0,
    input  limb_t       a_limb1,
    input  limb_t       a_limb2,
    input  limb_t       a_limb3,
    input  limb_t       b_limb0,
    input  limb_t       b_limb1,
    input  limb_t       b_limb2,
    input  limb_t       b_limb3,
    output logic        done,
    output limb_t       product_limb0,
    output limb_t       product_limb1,
    output limb_t       product_limb2,
    output limb_t       product_limb3
);

`include "assert_macros.svh"

    num_t  modulus_reg;
    limb_t neg_inverse_reg;
    logic  v [LimbCount+1];
    num_t  bb [LimbCount+1];
    num_t  aa [LimbCount+1];
    acc_t  tt [LimbCount+1];
    num_t  res;
    logic  accept;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg     <= '0;
            neg_inverse_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (int'(cfg_index) < LimbCount)
                modulus_reg[cfg_index[1:0]] <= cfg_data;
            else if (int'(cfg_index) == RegNegInv)
                neg_inverse_reg <= cfg_data;
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign v[0]  = accept;
    assign bb[0] = {b_limb3, b_limb2, b_limb1, b_limb0};
    assign aa[0] = {a_limb3, a_limb2, a_limb1, a_limb0};
    assign tt[0] = '0;

    // chain of cells, each consumes the lowest remaining limb of a
    for (genvar i = 0; i < LimbCount; i++)
    begin : g_cell
        mmm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (v[i]),
            .a_limb     (aa[i][0]),
            .b          (bb[i]),
            .a_rest     ({limb_t'(0), aa[i][LimbCount-1:1]}),
            .t_in       (tt[i]),
            .modulus    (modulus_reg),
            .neg_inverse(neg_inverse_reg),
            .out_valid  (v[i+1]),
            .b_out      (bb[i+1]),
            .a_rest_out (aa[i+1]),
            .t_out      (tt[i+1])
        );
    end

    mmm_final u_final (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v[LimbCount]),
        .t_in     (tt[LimbCount]),
        .modulus  (modulus_reg),
        .out_valid(done),
        .res      (res)
    );

    assign product_limb0 = res[0];
    assign product_limb1 = res[1];
    assign product_limb2 = res[2];
    assign product_limb3 = res[3];

    `ASSERT_IMPL(a_start_flows, clk, rst_n, v[1], $past(v[0], CellStages))
    `ASSERT_NEXT(a_chain_to_done, clk, rst_n, v[LimbCount], done)
    `ASSERT_IMPL(a_done_from_chain, clk, rst_n, done, $past(v[LimbCount]))
    `ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy)

endmodule

`default_nettype wire
